>>> rtl/pibo_pkg.sv
`default_nettype none
package pibo_pkg;

	localparam int PosW     = 32;
	localparam int VelW     = 24;
	localparam int DtW      = 17;
	localparam int MarginW  = 23;
	localparam int FracW    = 16;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;

	// sums are formed two bits wider than a position so nothing wraps
	localparam int SumW = PosW + 2;

	localparam logic signed [SumW-1:0] S32_MAX = 34'sd2147483647;
	localparam logic signed [SumW-1:0] S32_MIN = -34'sd2147483648;

	localparam logic signed [PosW-1:0] VEL_LIMIT   = 32'sd6553600;
	localparam logic signed [VelW-1:0] BOTTOM_KICK = 24'sd1966; // 0.03, truncated

	localparam logic [DtW-1:0]            RST_TIME_STEP = 17'd66;
	localparam logic signed [PosW-1:0]    RST_BOTTOM    = 32'sd0;
	localparam logic signed [PosW-1:0]    RST_TOP       = 32'sd6553600;
	localparam logic signed [PosW-1:0]    RST_LEFT      = 32'sd0;
	localparam logic signed [PosW-1:0]    RST_RIGHT     = 32'sd6553600;
	localparam logic [MarginW-1:0]        RST_MARGIN    = 23'd65536;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TIME_STEP = 3'd0,
		CFG_BOTTOM    = 3'd1,
		CFG_TOP       = 3'd2,
		CFG_LEFT      = 3'd3,
		CFG_RIGHT     = 3'd4,
		CFG_MARGIN    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [PosW-1:0] pos_x;
		logic signed [PosW-1:0] pos_y;
		logic signed [VelW-1:0] vel_x;
		logic signed [VelW-1:0] vel_y;
		logic signed [PosW-1:0] acc_x;
		logic signed [PosW-1:0] acc_y;
	} particle_in_t;

	typedef struct packed {
		logic signed [PosW-1:0] new_pos_x;
		logic signed [PosW-1:0] new_pos_y;
		logic signed [VelW-1:0] new_vel_x;
		logic signed [VelW-1:0] new_vel_y;
		logic                   wall_hit;
	} particle_out_t;

	function automatic logic signed [PosW-1:0] sat32(input logic signed [SumW-1:0] x);
		logic signed [SumW-1:0] r;
		if (x > S32_MAX) begin
			r = S32_MAX;
		end else if (x < S32_MIN) begin
			r = S32_MIN;
		end else begin
			r = x;
		end
		return r[PosW-1:0];
	endfunction

	function automatic logic signed [VelW-1:0] clampv(input logic signed [PosW-1:0] x);
		logic signed [PosW-1:0] r;
		if (x > VEL_LIMIT) begin
			r = VEL_LIMIT;
		end else if (x < -VEL_LIMIT) begin
			r = -VEL_LIMIT;
		end else begin
			r = x;
		end
		return r[VelW-1:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/pibo_dt_mul.sv
`default_nettype none
// registered product of the unsigned step and a signed operand
module pibo_dt_mul #(
	parameter int W = pibo_pkg::PosW
) (
	input  wire                                     clk,
	input  wire  [pibo_pkg::DtW-1:0]                dt,
	input  wire  signed [W-1:0]                     x,
	output logic signed [W+pibo_pkg::DtW:0]         prod_s
);

	always_ff @(posedge clk) begin
		prod_s <= $signed({1'b0, dt}) * x;
	end

endmodule
`default_nettype wire

>>> rtl/particle_integrate_and_bounce_top.sv
`default_nettype none
// One semi-implicit Euler step per particle in signed Q16.16, with wall
// reflection. A request is taken whenever start is high; busy never rises,
// so a new particle may be issued every clock. Each result appears on
// result for one cycle with done high, in request order. The receiver
// cannot stall: results must be captured when done is high. The pipeline
// is built from the three chained step multiplications (dt*a, then dt*v,
// and dt*v again after a reflection), each with its own register stage,
// plus the saturating adds and wall compares between them. Configuration
// (step, four walls, margin) is written through the cfg channel, which is
// always ready; write it only while no request is in flight. Indices
// beyond the margin register are ignored.
module particle_integrate_and_bounce_top (
	input  wire                                clk,
	input  wire                                arst_n,
	// request channel
	input  wire                                start,
	output logic                               busy,
	input  wire  pibo_pkg::particle_in_t       request,
	// result channel
	output logic                               done,
	output pibo_pkg::particle_out_t            result,
	// configuration
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [pibo_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire  [pibo_pkg::CfgDataW-1:0]      cfg_data
);

	localparam int PW  = pibo_pkg::PosW;
	localparam int VW  = pibo_pkg::VelW;
	localparam int SW  = pibo_pkg::SumW;
	localparam int FW  = pibo_pkg::FracW;
	localparam int DW  = pibo_pkg::DtW;
	localparam int AP  = PW + DW + 1; // dt*a product width
	localparam int VP  = VW + DW + 1; // dt*v product width

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [DW-1:0]                   dt_q;
	logic signed [PW-1:0]            bottom_q, top_q, left_q, right_q;
	logic [pibo_pkg::MarginW-1:0]    margin_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q     <= pibo_pkg::RST_TIME_STEP;
			bottom_q <= pibo_pkg::RST_BOTTOM;
			top_q    <= pibo_pkg::RST_TOP;
			left_q   <= pibo_pkg::RST_LEFT;
			right_q  <= pibo_pkg::RST_RIGHT;
			margin_q <= pibo_pkg::RST_MARGIN;
		end else if (cfg_valid && cfg_ready) begin
			case (pibo_pkg::cfg_idx_t'(cfg_index))
				pibo_pkg::CFG_TIME_STEP: dt_q     <= cfg_data[DW-1:0];
				pibo_pkg::CFG_BOTTOM:    bottom_q <= cfg_data[PW-1:0];
				pibo_pkg::CFG_TOP:       top_q    <= cfg_data[PW-1:0];
				pibo_pkg::CFG_LEFT:      left_q   <= cfg_data[PW-1:0];
				pibo_pkg::CFG_RIGHT:     right_q  <= cfg_data[PW-1:0];
				pibo_pkg::CFG_MARGIN:    margin_q <= cfg_data[pibo_pkg::MarginW-1:0];
				default: ; // out-of-range index: dropped
			endcase
		end
	end

	// wall thresholds; the user keeps config static while particles flow, the block does not enforce it
	logic signed [SW-1:0] margin_x;
	logic signed [PW-1:0] bot_thr, top_thr, left_thr, right_thr;

	assign margin_x  = $signed({{(SW-pibo_pkg::MarginW){1'b0}}, margin_q});
	assign bot_thr   = pibo_pkg::sat32(SW'(bottom_q) + margin_x);
	assign top_thr   = pibo_pkg::sat32(SW'(top_q) - margin_x);
	assign left_thr  = pibo_pkg::sat32(SW'(left_q) + margin_x);
	assign right_thr = pibo_pkg::sat32(SW'(right_q) - margin_x);

	// ---------------------------------------------------------------
	// Valid chain
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			done_q   <= valid_s6;
		end
	end

	assign done = done_q;

	// ---------------------------------------------------------------
	// S1: dt*a
	// ---------------------------------------------------------------
	logic signed [AP-1:0] ax_prod_s1, ay_prod_s1;
	logic signed [PW-1:0] px_s1, py_s1;
	logic signed [VW-1:0] vx_s1, vy_s1;

	pibo_dt_mul #(.W(PW)) u_mul_ax (
		.clk(clk), .dt(dt_q), .x(request.acc_x), .prod_s(ax_prod_s1)
	);
	pibo_dt_mul #(.W(PW)) u_mul_ay (
		.clk(clk), .dt(dt_q), .x(request.acc_y), .prod_s(ay_prod_s1)
	);

	always_ff @(posedge clk) begin
		px_s1 <= request.pos_x;
		py_s1 <= request.pos_y;
		vx_s1 <= request.vel_x;
		vy_s1 <= request.vel_y;
	end

	// ---------------------------------------------------------------
	// S2: v = clamp(sat(v + floor(dt*a)))
	// ---------------------------------------------------------------
	logic signed [PW-1:0] dvx, dvy;
	logic signed [VW-1:0] vx_s2, vy_s2;
	logic signed [PW-1:0] px_s2, py_s2;

	// arithmetic shift right is the floor of the scaled product
	assign dvx = pibo_pkg::sat32(ax_prod_s1[AP-1:FW]);
	assign dvy = pibo_pkg::sat32(ay_prod_s1[AP-1:FW]);

	always_ff @(posedge clk) begin
		vx_s2 <= pibo_pkg::clampv(pibo_pkg::sat32(SW'(vx_s1) + SW'(dvx)));
		vy_s2 <= pibo_pkg::clampv(pibo_pkg::sat32(SW'(vy_s1) + SW'(dvy)));
		px_s2 <= px_s1;
		py_s2 <= py_s1;
	end

	// ---------------------------------------------------------------
	// S3: dt*v
	// ---------------------------------------------------------------
	logic signed [VP-1:0] vx_prod_s3, vy_prod_s3;
	logic signed [VW-1:0] vx_s3, vy_s3;
	logic signed [PW-1:0] px_s3, py_s3;

	pibo_dt_mul #(.W(VW)) u_mul_vx (
		.clk(clk), .dt(dt_q), .x(vx_s2), .prod_s(vx_prod_s3)
	);
	pibo_dt_mul #(.W(VW)) u_mul_vy (
		.clk(clk), .dt(dt_q), .x(vy_s2), .prod_s(vy_prod_s3)
	);

	always_ff @(posedge clk) begin
		vx_s3 <= vx_s2;
		vy_s3 <= vy_s2;
		px_s3 <= px_s2;
		py_s3 <= py_s2;
	end

	// ---------------------------------------------------------------
	// S4: p = sat(p + floor(dt*v)); the step never exceeds 32 bits
	// ---------------------------------------------------------------
	logic signed [VW-1:0] vx_s4, vy_s4;
	logic signed [PW-1:0] px_s4, py_s4;

	always_ff @(posedge clk) begin
		px_s4 <= pibo_pkg::sat32(SW'(px_s3) + SW'($signed(vx_prod_s3[VP-1:FW])));
		py_s4 <= pibo_pkg::sat32(SW'(py_s3) + SW'($signed(vy_prod_s3[VP-1:FW])));
		vx_s4 <= vx_s3;
		vy_s4 <= vy_s3;
	end

	// ---------------------------------------------------------------
	// S5: wall tests and reflection; top beats bottom, right beats left
	// ---------------------------------------------------------------
	logic                 hit_bot, hit_top, hit_left, hit_right;
	logic signed [VW-1:0] abs_vx, abs_vy, vx_ref, vy_ref;
	logic signed [VW-1:0] vx_s5, vy_s5;
	logic signed [PW-1:0] px_s5, py_s5;
	logic                 hit_s5;

	assign hit_bot   = py_s4 < bot_thr;
	assign hit_top   = py_s4 > top_thr;
	assign hit_left  = px_s4 < left_thr;
	assign hit_right = px_s4 > right_thr;

	// velocities are clamped here, so negation cannot overflow
	assign abs_vx = vx_s4[VW-1] ? -vx_s4 : vx_s4;
	assign abs_vy = vy_s4[VW-1] ? -vy_s4 : vy_s4;

	always_comb begin
		vy_ref = vy_s4;
		if (hit_top) begin
			// a bottom kick applied first is carried into the top reflection
			vy_ref = hit_bot ? -(abs_vy + pibo_pkg::BOTTOM_KICK) : -abs_vy;
		end else if (hit_bot) begin
			vy_ref = abs_vy + pibo_pkg::BOTTOM_KICK;
		end
		vx_ref = vx_s4;
		if (hit_right) begin
			vx_ref = -abs_vx;
		end else if (hit_left) begin
			vx_ref = abs_vx;
		end
	end

	always_ff @(posedge clk) begin
		vx_s5  <= vx_ref;
		vy_s5  <= vy_ref;
		px_s5  <= px_s4;
		py_s5  <= py_s4;
		hit_s5 <= hit_bot || hit_top || hit_left || hit_right;
	end

	// ---------------------------------------------------------------
	// S6: dt*v with reflected velocity
	// ---------------------------------------------------------------
	logic signed [VP-1:0] rx_prod_s6, ry_prod_s6;
	logic signed [VW-1:0] vx_s6, vy_s6;
	logic signed [PW-1:0] px_s6, py_s6;
	logic                 hit_s6;

	pibo_dt_mul #(.W(VW)) u_mul_rx (
		.clk(clk), .dt(dt_q), .x(vx_s5), .prod_s(rx_prod_s6)
	);
	pibo_dt_mul #(.W(VW)) u_mul_ry (
		.clk(clk), .dt(dt_q), .x(vy_s5), .prod_s(ry_prod_s6)
	);

	always_ff @(posedge clk) begin
		vx_s6  <= vx_s5;
		vy_s6  <= vy_s5;
		px_s6  <= px_s5;
		py_s6  <= py_s5;
		hit_s6 <= hit_s5;
	end

	// ---------------------------------------------------------------
	// S7: second advance on a hit, final clamp, output register
	// ---------------------------------------------------------------
	pibo_pkg::particle_out_t result_q;

	always_ff @(posedge clk) begin
		result_q.wall_hit <= hit_s6;
		if (hit_s6) begin
			result_q.new_pos_x <= pibo_pkg::sat32(SW'(px_s6) +
			                                      SW'($signed(rx_prod_s6[VP-1:FW])));
			result_q.new_pos_y <= pibo_pkg::sat32(SW'(py_s6) +
			                                      SW'($signed(ry_prod_s6[VP-1:FW])));
			result_q.new_vel_x <= pibo_pkg::clampv(PW'(vx_s6));
			result_q.new_vel_y <= pibo_pkg::clampv(PW'(vy_s6));
		end else begin
			result_q.new_pos_x <= px_s6;
			result_q.new_pos_y <= py_s6;
			result_q.new_vel_x <= vx_s6;
			result_q.new_vel_y <= vy_s6;
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire
